/* rtl/core/psd_pkg.sv */
// Shared types, widths, codes and helpers for the point to segment distance pipeline.
package psd_pkg;

	localparam int CW         = 24;           // coordinate width, Q12.12
	localparam int DIR_W      = 16;           // direction width, Q1.14
	localparam int DIR_FRAC   = 14;
	localparam int TIME_W     = 16;           // time width, Q8.8
	localparam int TIME_FRAC  = 8;
	localparam int DIST_W     = 52;
	localparam int ROOT_W     = DIST_W / 2;
	localparam int ROOT_STAGES = ROOT_W;      // one root bit per stage
	localparam int REM_W      = ROOT_W + 2;
	localparam int GEO_STAGES = 11;
	localparam int PIPE_LAT   = GEO_STAGES + ROOT_STAGES;

	localparam int TPROD_W = TIME_W + 1 + CW; // time times velocity
	localparam int D_W     = CW + 1;          // point minus centre
	localparam int DPROD_W = D_W + DIR_W;     // difference times direction
	localparam int P_W     = DPROD_W + 1;     // projection sum
	localparam int TUX_W   = CW + DIR_W;      // parameter times direction
	localparam int N_W     = CW + 2;          // unsaturated nearest point
	localparam int E_W     = CW + 3;          // nearest point minus query point
	localparam int SAT_IN_W = 48;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [1:0] CASE_INTERIOR = 2'd0;
	localparam logic [1:0] CASE_POS_END  = 2'd1;
	localparam logic [1:0] CASE_NEG_END  = 2'd2;

	typedef logic signed [CW-1:0]    coord_t;
	typedef logic signed [DIR_W-1:0] dir_t;
	typedef logic [CW-2:0]           ext_t;
	typedef logic [TIME_W-1:0]       time_t;
	typedef logic [DIST_W-1:0]       dist_t;
	typedef logic [ROOT_W-1:0]       root_t;
	typedef logic [1:0]              kase_t;

	typedef struct packed {
		dist_t         sq;
		logic [CW-1:0] near_x;
		logic [CW-1:0] near_y;
		kase_t         kase;
	} psd_res_t;

	// Clamp a wide signed value to the signed coordinate range.
	function automatic logic [CW-1:0] sat_coord(input logic signed [SAT_IN_W-1:0] x);
		logic [SAT_IN_W-CW:0] top;
		top = x[SAT_IN_W-1:CW-1];
		if (top == '0 || top == '1) begin
			return x[CW-1:0];
		end else if (x[SAT_IN_W-1]) begin
			return {1'b1, {(CW-1){1'b0}}};
		end else begin
			return {1'b0, {(CW-1){1'b1}}};
		end
	endfunction

endpackage

/* rtl/core/psd_sqrt.sv */
// Pipelined integer square root, one result bit resolved per stage.
module psd_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  psd_pkg::dist_t  in_val,
	output logic            out_vld,
	output psd_pkg::root_t  out_root
);
	import psd_pkg::*;

	logic [REM_W-1:0]  rem_s  [1:ROOT_STAGES];
	root_t             root_s [1:ROOT_STAGES];
	dist_t             val_s  [1:ROOT_STAGES];
	logic [ROOT_STAGES:1] vld_s;

	for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_stage
		logic [REM_W-1:0] rem_i;
		root_t            root_i;
		dist_t            val_i;
		logic             vld_i;
		logic [REM_W-1:0] rem_c;
		logic [REM_W-1:0] trial_c;
		logic             ge_c;

		// The first stage starts from an empty remainder and root.
		if (i == 0) begin : g_head
			assign rem_i  = '0;
			assign root_i = '0;
			assign val_i  = in_val;
			assign vld_i  = in_vld;
		end else begin : g_body
			assign rem_i  = rem_s[i];
			assign root_i = root_s[i];
			assign val_i  = val_s[i];
			assign vld_i  = vld_s[i];
		end

		// Bring down the next two radicand bits and try the next root bit.
		always_comb begin
			rem_c   = {rem_i[REM_W-3:0], val_i[DIST_W-1 -: 2]};
			trial_c = {root_i, 2'b01};
			ge_c    = rem_c >= trial_c;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= ge_c ? rem_c - trial_c : rem_c;
			root_s[i+1] <= {root_i[ROOT_W-2:0], ge_c};
			val_s[i+1]  <= {val_i[DIST_W-3:0], 2'b00};
		end
	end

	assign out_vld  = vld_s[ROOT_STAGES];
	assign out_root = root_s[ROOT_STAGES];

	a_root_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> ((54'(out_root) * 54'(out_root)) <= 54'($past(in_val, ROOT_STAGES))))
		else $error("root squared exceeds radicand");

	a_root_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> (((54'(out_root) + 54'd1) * (54'(out_root) + 54'd1)) >
			54'($past(in_val, ROOT_STAGES))))
		else $error("root is not the floor root");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> (rem_s[ROOT_STAGES] <= REM_W'({out_root, 1'b0})))
		else $error("final remainder above twice the root");

endmodule

/* rtl/core/point_segment_distance_2d.sv */
// A request passes through 11 geometry stages and then 26 root stages to its done strobe.
// Throughput: one request per clock; busy stays low since every stage advances every cycle.
// The rate is set by the fully pipelined multipliers and the one-bit-per-stage root pipeline.
// The receiver cannot stall, so each result appears for exactly one cycle with done high.
// Reset clears all valid bits and want_root; data registers are not reset.
module point_segment_distance_2d (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  psd_pkg::coord_t  point_x,
	input  psd_pkg::coord_t  point_y,
	input  psd_pkg::coord_t  seg_center_x,
	input  psd_pkg::coord_t  seg_center_y,
	input  psd_pkg::dir_t    seg_dir_x,
	input  psd_pkg::dir_t    seg_dir_y,
	input  psd_pkg::ext_t    seg_half_length,
	input  psd_pkg::time_t   move_time,
	input  psd_pkg::coord_t  point_vel_x,
	input  psd_pkg::coord_t  point_vel_y,
	input  psd_pkg::coord_t  seg_vel_x,
	input  psd_pkg::coord_t  seg_vel_y,
	output logic             done,
	output psd_pkg::dist_t   distance,
	output psd_pkg::coord_t  near_x,
	output psd_pkg::coord_t  near_y,
	output psd_pkg::kase_t   clamp_case
);
	import psd_pkg::*;

	logic want_root_q;
	logic [GEO_STAGES-1:0] vld_q;
	logic accept;

	// Stage 1: time products.
	logic signed [TPROD_W-1:0] tpx_s1, tpy_s1, tcx_s1, tcy_s1;
	coord_t px_s1, py_s1, cx_s1, cy_s1;
	dir_t   ux_s1, uy_s1;
	ext_t   ext_s1;
	// Stage 2: moved coordinates.
	coord_t px_s2, py_s2, cx_s2, cy_s2;
	dir_t   ux_s2, uy_s2;
	ext_t   ext_s2;
	// Stage 3: offset from the centre.
	logic signed [D_W-1:0] dx_s3, dy_s3;
	coord_t px_s3, py_s3, cx_s3, cy_s3;
	dir_t   ux_s3, uy_s3;
	ext_t   ext_s3;
	// Stage 4: dot product terms.
	logic signed [DPROD_W-1:0] dux_s4, duy_s4;
	coord_t px_s4, py_s4, cx_s4, cy_s4;
	dir_t   ux_s4, uy_s4;
	ext_t   ext_s4;
	// Stage 5: clamped parameter.
	coord_t tp_s5;
	kase_t  kase_s5;
	coord_t px_s5, py_s5, cx_s5, cy_s5;
	dir_t   ux_s5, uy_s5;
	// Stage 6: parameter times direction.
	logic signed [TUX_W-1:0] tux_s6, tuy_s6;
	kase_t  kase_s6;
	coord_t px_s6, py_s6, cx_s6, cy_s6;
	// Stage 7: unsaturated nearest point.
	logic signed [N_W-1:0] nx_s7, ny_s7;
	kase_t  kase_s7;
	coord_t px_s7, py_s7;
	// Stage 8: error vector and saturated nearest point.
	logic signed [E_W-1:0] ex_s8, ey_s8;
	logic [CW-1:0] nearx_s8, neary_s8;
	kase_t kase_s8;
	// Stage 9: magnitudes.
	logic [E_W-1:0] magx_s9, magy_s9;
	logic [CW-1:0] nearx_s9, neary_s9;
	kase_t kase_s9;
	// Stage 10: squares.
	dist_t sqx_s10, sqy_s10;
	logic [CW-1:0] nearx_s10, neary_s10;
	kase_t kase_s10;
	// Stage 11: squared distance.
	psd_res_t res_s11;

	psd_res_t side_s [1:ROOT_STAGES];
	logic  root_vld;
	root_t root_val;

	logic signed [P_W-1:0] sum_c, p_c, ext_w_c;
	coord_t ext_pos_c;
	logic   above_neg_c, below_pos_c;
	logic [DIST_W:0] sqsum_c;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_root_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			if (cfg_we) begin
				want_root_q <= cfg_wdata;
			end
			vld_q <= {vld_q[GEO_STAGES-2:0], accept};
		end
	end

	// Projection and clamp; interior only when strictly inside both ends.
	always_comb begin
		sum_c       = P_W'(dux_s4) + P_W'(duy_s4);
		p_c         = sum_c >>> DIR_FRAC;
		ext_w_c     = P_W'($signed({1'b0, ext_s4}));
		ext_pos_c   = $signed({1'b0, ext_s4});
		above_neg_c = -ext_w_c < p_c;
		below_pos_c = p_c < ext_w_c;
		sqsum_c     = {1'b0, sqx_s10} + {1'b0, sqy_s10};
	end

	always_ff @(posedge clk) begin
		// Stage 1
		tpx_s1 <= $signed({1'b0, move_time}) * point_vel_x;
		tpy_s1 <= $signed({1'b0, move_time}) * point_vel_y;
		tcx_s1 <= $signed({1'b0, move_time}) * seg_vel_x;
		tcy_s1 <= $signed({1'b0, move_time}) * seg_vel_y;
		px_s1  <= point_x;
		py_s1  <= point_y;
		cx_s1  <= seg_center_x;
		cy_s1  <= seg_center_y;
		ux_s1  <= seg_dir_x;
		uy_s1  <= seg_dir_y;
		ext_s1 <= seg_half_length;
		// Stage 2
		px_s2  <= sat_coord(SAT_IN_W'(px_s1) + SAT_IN_W'(tpx_s1 >>> TIME_FRAC));
		py_s2  <= sat_coord(SAT_IN_W'(py_s1) + SAT_IN_W'(tpy_s1 >>> TIME_FRAC));
		cx_s2  <= sat_coord(SAT_IN_W'(cx_s1) + SAT_IN_W'(tcx_s1 >>> TIME_FRAC));
		cy_s2  <= sat_coord(SAT_IN_W'(cy_s1) + SAT_IN_W'(tcy_s1 >>> TIME_FRAC));
		ux_s2  <= ux_s1;
		uy_s2  <= uy_s1;
		ext_s2 <= ext_s1;
		// Stage 3
		dx_s3  <= D_W'(px_s2) - D_W'(cx_s2);
		dy_s3  <= D_W'(py_s2) - D_W'(cy_s2);
		px_s3  <= px_s2;
		py_s3  <= py_s2;
		cx_s3  <= cx_s2;
		cy_s3  <= cy_s2;
		ux_s3  <= ux_s2;
		uy_s3  <= uy_s2;
		ext_s3 <= ext_s2;
		// Stage 4
		dux_s4 <= dx_s3 * ux_s3;
		duy_s4 <= dy_s3 * uy_s3;
		px_s4  <= px_s3;
		py_s4  <= py_s3;
		cx_s4  <= cx_s3;
		cy_s4  <= cy_s3;
		ux_s4  <= ux_s3;
		uy_s4  <= uy_s3;
		ext_s4 <= ext_s3;
		// Stage 5
		if (above_neg_c && below_pos_c) begin
			tp_s5   <= CW'(p_c);
			kase_s5 <= CASE_INTERIOR;
		end else if (above_neg_c) begin
			tp_s5   <= ext_pos_c;
			kase_s5 <= CASE_POS_END;
		end else begin
			tp_s5   <= -ext_pos_c;
			kase_s5 <= CASE_NEG_END;
		end
		px_s5 <= px_s4;
		py_s5 <= py_s4;
		cx_s5 <= cx_s4;
		cy_s5 <= cy_s4;
		ux_s5 <= ux_s4;
		uy_s5 <= uy_s4;
		// Stage 6
		tux_s6  <= tp_s5 * ux_s5;
		tuy_s6  <= tp_s5 * uy_s5;
		kase_s6 <= kase_s5;
		px_s6   <= px_s5;
		py_s6   <= py_s5;
		cx_s6   <= cx_s5;
		cy_s6   <= cy_s5;
		// Stage 7
		nx_s7   <= N_W'(cx_s6) + N_W'(tux_s6 >>> DIR_FRAC);
		ny_s7   <= N_W'(cy_s6) + N_W'(tuy_s6 >>> DIR_FRAC);
		kase_s7 <= kase_s6;
		px_s7   <= px_s6;
		py_s7   <= py_s6;
		// Stage 8: the distance uses the nearest point before saturation.
		ex_s8    <= E_W'(nx_s7) - E_W'(px_s7);
		ey_s8    <= E_W'(ny_s7) - E_W'(py_s7);
		nearx_s8 <= sat_coord(SAT_IN_W'(nx_s7));
		neary_s8 <= sat_coord(SAT_IN_W'(ny_s7));
		kase_s8  <= kase_s7;
		// Stage 9
		magx_s9  <= ex_s8[E_W-1] ? E_W'(-ex_s8) : E_W'(ex_s8);
		magy_s9  <= ey_s8[E_W-1] ? E_W'(-ey_s8) : E_W'(ey_s8);
		nearx_s9 <= nearx_s8;
		neary_s9 <= neary_s8;
		kase_s9  <= kase_s8;
		// Stage 10
		sqx_s10 <= (|magx_s9[E_W-1:ROOT_W]) ? DIST_MAX :
			magx_s9[ROOT_W-1:0] * magx_s9[ROOT_W-1:0];
		sqy_s10 <= (|magy_s9[E_W-1:ROOT_W]) ? DIST_MAX :
			magy_s9[ROOT_W-1:0] * magy_s9[ROOT_W-1:0];
		nearx_s10 <= nearx_s9;
		neary_s10 <= neary_s9;
		kase_s10  <= kase_s9;
		// Stage 11
		res_s11.sq     <= sqsum_c[DIST_W] ? DIST_MAX : sqsum_c[DIST_W-1:0];
		res_s11.near_x <= nearx_s10;
		res_s11.near_y <= neary_s10;
		res_s11.kase   <= kase_s10;
		// Side data runs alongside the root pipeline.
		side_s[1] <= res_s11;
		for (int i = 2; i <= ROOT_STAGES; i++) begin
			side_s[i] <= side_s[i-1];
		end
	end

	psd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_q[GEO_STAGES-1]),
		.in_val   (res_s11.sq),
		.out_vld  (root_vld),
		.out_root (root_val)
	);

	assign done       = root_vld;
	assign distance   = want_root_q ? DIST_W'(root_val) : side_s[ROOT_STAGES].sq;
	assign near_x     = side_s[ROOT_STAGES].near_x;
	assign near_y     = side_s[ROOT_STAGES].near_y;
	assign clamp_case = side_s[ROOT_STAGES].kase;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##PIPE_LAT done)
		else $error("request did not complete after the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> ##PIPE_LAT !done)
		else $error("done without a matching request");

	a_side_align: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !want_root_q) |-> (distance == $past(res_s11.sq, ROOT_STAGES)))
		else $error("side data out of step with root pipeline");

endmodule

/* verif/tb_point_segment_distance_2d.sv */
// Self-checking testbench for the point to segment distance pipeline.
`timescale 1ns / 100ps

module tb_point_segment_distance_2d;
	import psd_pkg::*;

	typedef struct packed {
		coord_t px;
		coord_t py;
		coord_t cx;
		coord_t cy;
		dir_t   ux;
		dir_t   uy;
		ext_t   ext;
		time_t  t;
		coord_t pvx;
		coord_t pvy;
		coord_t svx;
		coord_t svy;
	} query_t;

	localparam longint COORD_HI = longint'(2 ** (CW - 1)) - 1;
	localparam longint COORD_LO = -COORD_HI - 1;
	localparam int UNIT_Q14 = 16384;
	localparam int UNIT_COS [6] = '{16384, 15826, 14189, 11585, 8192, 4240};
	localparam int UNIT_SIN [6] = '{0, 4240, 8192, 11585, 14189, 15826};

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	logic   busy;
	logic   cfg_we = 1'b0;
	logic   cfg_wdata = 1'b0;
	query_t cur = '0;
	logic   done;
	dist_t  distance;
	coord_t near_x;
	coord_t near_y;
	kase_t  clamp_case;

	query_t   pending_queries[$];
	psd_res_t due_results[$];
	psd_res_t oldest;
	bit       root_mode = 1'b0;
	int       gap_pct = 0;
	int       fails = 0;
	int       checked = 0;
	int       root_checked = 0;
	int       case_count [3] = '{0, 0, 0};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	point_segment_distance_2d u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.point_x        (cur.px),
		.point_y        (cur.py),
		.seg_center_x   (cur.cx),
		.seg_center_y   (cur.cy),
		.seg_dir_x      (cur.ux),
		.seg_dir_y      (cur.uy),
		.seg_half_length(cur.ext),
		.move_time      (cur.t),
		.point_vel_x    (cur.pvx),
		.point_vel_y    (cur.pvy),
		.seg_vel_x      (cur.svx),
		.seg_vel_y      (cur.svy),
		.done           (done),
		.distance       (distance),
		.near_x         (near_x),
		.near_y         (near_y),
		.clamp_case     (clamp_case)
	);

	function automatic longint clamp_coord(longint v);
		if (v > COORD_HI) return COORD_HI;
		if (v < COORD_LO) return COORD_LO;
		return v;
	endfunction

	// Position after motion; the shift of a signed product rounds toward minus infinity.
	function automatic longint moved(longint pos, longint vel, longint t);
		return clamp_coord(pos + ((t * vel) >>> TIME_FRAC));
	endfunction

	function automatic longint unsigned square_capped(longint e);
		longint unsigned mag;
		mag = (e < 0) ? -e : e;
		if (mag >= (64'd1 << ROOT_W)) return DIST_MAX;
		return mag * mag;
	endfunction

	function automatic psd_res_t nearest_on_segment(query_t q, bit want_root);
		longint t, px, py, cx, cy, ux, uy, ext, p, tp, nx, ny;
		longint unsigned d, root, trial;
		psd_res_t r;
		t   = q.t;
		ux  = q.ux;
		uy  = q.uy;
		ext = q.ext;
		px  = moved(q.px, q.pvx, t);
		py  = moved(q.py, q.pvy, t);
		cx  = moved(q.cx, q.svx, t);
		cy  = moved(q.cy, q.svy, t);
		p   = ((px - cx) * ux + (py - cy) * uy) >>> DIR_FRAC;
		if (-ext < p && p < ext) begin
			tp = p;
			r.kase = CASE_INTERIOR;
		end else if (-ext < p) begin
			tp = ext;
			r.kase = CASE_POS_END;
		end else begin
			tp = -ext;
			r.kase = CASE_NEG_END;
		end
		nx = cx + ((tp * ux) >>> DIR_FRAC);
		ny = cy + ((tp * uy) >>> DIR_FRAC);
		// The distance is taken from the nearest point before it saturates.
		d = square_capped(nx - px) + square_capped(ny - py);
		if (d > DIST_MAX) d = DIST_MAX;
		if (want_root) begin
			root = 0;
			for (int i = ROOT_W - 1; i >= 0; i--) begin
				trial = root | (64'd1 << i);
				if (trial * trial <= d) root = trial;
			end
			d = root;
		end
		r.sq = dist_t'(d);
		r.near_x = coord_t'(clamp_coord(nx));
		r.near_y = coord_t'(clamp_coord(ny));
		return r;
	endfunction

	function automatic query_t static_query(longint px, longint py, longint cx, longint cy,
			longint ux, longint uy, longint ext);
		query_t q;
		q = '0;
		q.px = coord_t'(px);
		q.py = coord_t'(py);
		q.cx = coord_t'(cx);
		q.cy = coord_t'(cy);
		q.ux = dir_t'(ux);
		q.uy = dir_t'(uy);
		q.ext = ext_t'(ext);
		return q;
	endfunction

	function automatic coord_t rand_coord();
		int span;
		if ($urandom_range(0, 3) == 0) return coord_t'($urandom);
		span = 1 << $urandom_range(4, 18);
		return coord_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic query_t rand_query();
		query_t q;
		int idx, a, b;
		q.cx = rand_coord();
		q.cy = rand_coord();
		// Most points sit near the segment so that all three clamp cases show up.
		if ($urandom_range(0, 9) < 6) begin
			q.px = q.cx + rand_coord();
			q.py = q.cy + rand_coord();
		end else begin
			q.px = rand_coord();
			q.py = rand_coord();
		end
		if ($urandom_range(0, 9) < 7) begin
			idx = $urandom_range(0, 5);
			a = $urandom_range(0, 1) ? UNIT_COS[idx] : -UNIT_COS[idx];
			b = $urandom_range(0, 1) ? UNIT_SIN[idx] : -UNIT_SIN[idx];
			if ($urandom_range(0, 1)) begin
				q.ux = dir_t'(a);
				q.uy = dir_t'(b);
			end else begin
				q.ux = dir_t'(b);
				q.uy = dir_t'(a);
			end
		end else begin
			q.ux = dir_t'($urandom);
			q.uy = dir_t'($urandom);
		end
		case ($urandom_range(0, 19))
			0, 1:    q.ext = '0;
			2:       q.ext = '1;
			3, 4, 5: q.ext = ext_t'($urandom);
			default: q.ext = ext_t'($urandom_range(0, 1 << $urandom_range(4, 20)));
		endcase
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5: q.t = '0;
			6, 7, 8, 9, 10:   q.t = time_t'($urandom);
			default:          q.t = time_t'($urandom_range(0, 1024));
		endcase
		q.pvx = rand_coord();
		q.pvy = rand_coord();
		q.svx = rand_coord();
		q.svy = rand_coord();
		return q;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	// Driver: a request is taken at an edge where start is high and busy is low.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) due_results.push_back(nearest_on_segment(cur, root_mode));
			if (!start || !busy) begin
				if (pending_queries.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
					cur <= pending_queries.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done strobe carries one result.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				$error("result with no request outstanding");
				fails++;
			end else begin
				oldest = due_results.pop_front();
				check_field("distance", oldest.sq, distance);
				check_field("near_x", coord_t'(oldest.near_x), near_x);
				check_field("near_y", coord_t'(oldest.near_y), near_y);
				check_field("clamp_case", oldest.kase, clamp_case);
				checked++;
				if (root_mode) root_checked++;
				if (oldest.kase <= CASE_NEG_END) case_count[oldest.kase]++;
			end
		end
	end

	task automatic drain();
		do @(negedge clk);
		while (pending_queries.size() != 0 || start || due_results.size() != 0);
	endtask

	task automatic set_root(bit v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		root_mode = v;
		@(negedge clk);
	endtask

	task automatic queue_random(int n, int gap);
		gap_pct = gap;
		repeat (n) pending_queries.push_back(rand_query());
	endtask

	initial begin
		query_t q;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		gap_pct = 23;

		// Zero extent with the point on the centre falls to the negative end.
		pending_queries.push_back(static_query(0, 0, 0, 0, 0, 0, 0));
		pending_queries.push_back(static_query(12288, 20480, 0, 0, UNIT_Q14, 0, 40960));
		pending_queries.push_back(static_query(40960, 100, 0, 0, UNIT_Q14, 0, 40960));
		pending_queries.push_back(static_query(-40960, 0, 0, 0, UNIT_Q14, 0, 40960));
		pending_queries.push_back(static_query(-100000, 7, 0, 0, UNIT_Q14, 0, 40960));
		pending_queries.push_back(static_query(1, -3, 0, 0, 11585, 11585, 4096));
		pending_queries.push_back(static_query(-5, 9, 3, -2, -11585, 11585, 100000));
		pending_queries.push_back(static_query(COORD_HI, COORD_HI, COORD_LO, COORD_LO,
			-32768, -32768, 2 ** 23 - 1));
		pending_queries.push_back(static_query(COORD_HI, COORD_LO, COORD_LO, COORD_HI,
			32767, 32767, 2 ** 23 - 1));
		pending_queries.push_back(static_query(COORD_HI, COORD_HI, COORD_LO, COORD_LO,
			0, UNIT_Q14, 2 ** 23 - 1));
		pending_queries.push_back(static_query(COORD_LO, COORD_LO, COORD_HI, COORD_HI,
			-UNIT_Q14, 0, 0));
		pending_queries.push_back(static_query(300000, -700000, 0, 0, 0, -UNIT_Q14,
			2 ** 23 - 1));
		// A nearest point on the coordinate limit, and one beyond the range on the negative side.
		pending_queries.push_back(static_query(COORD_HI, 0, COORD_HI, 0, UNIT_Q14, 0,
			2 ** 23 - 1));
		pending_queries.push_back(static_query(COORD_LO, COORD_HI, COORD_LO, COORD_LO,
			-UNIT_Q14, UNIT_Q14, 4096));
		pending_queries.push_back(static_query(17, 0, 0, 0, 0, 0, 5));
		// Motion: saturation of every moved coordinate, and floor rounding.
		q = static_query(0, 0, 0, 0, UNIT_Q14, 0, 4096);
		q.t = '1;
		q.pvx = coord_t'(COORD_HI);
		q.pvy = coord_t'(COORD_LO);
		q.svx = coord_t'(COORD_LO);
		q.svy = coord_t'(COORD_HI);
		pending_queries.push_back(q);
		q.pvx = coord_t'(COORD_LO);
		q.pvy = coord_t'(COORD_LO);
		q.svy = coord_t'(COORD_LO);
		pending_queries.push_back(q);
		q = static_query(5, 5, 0, 0, 0, UNIT_Q14, 2048);
		q.t = 16'd1;
		q.pvx = coord_t'(-1);
		q.pvy = coord_t'(-1);
		q.svx = coord_t'(-1);
		q.svy = coord_t'(-3);
		pending_queries.push_back(q);
		q = static_query(-8192, 4096, 0, 0, UNIT_Q14, 0, 8192);
		q.t = 16'd256;
		q.pvx = coord_t'(4096);
		pending_queries.push_back(q);
		q.t = 16'h8000;
		q.svy = coord_t'(8);
		q.svx = coord_t'(-12345);
		pending_queries.push_back(q);
		drain();

		set_root(1'b1);
		queue_random(200, 23);
		drain();
		// This phase runs without any gaps in the request stream.
		set_root(1'b0);
		queue_random(200, 0);
		drain();
		set_root(1'b1);
		queue_random(250, 23);
		drain();
		repeat (PIPE_LAT + 8) @(posedge clk);

		$display("%0d results checked, %0d of them in root mode", checked, root_checked);
		$display("clamp cases seen: interior %0d, positive end %0d, negative end %0d",
			case_count[0], case_count[1], case_count[2]);
		if (fails == 0) begin
			$display("point_segment_distance_2d: match");
		end else begin
			$display("point_segment_distance_2d: mismatch");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("point_segment_distance_2d: mismatch");
		$finish;
	end

endmodule

/* point_segment_distance_2d.f */
rtl/core/psd_pkg.sv
rtl/core/psd_sqrt.sv
rtl/core/point_segment_distance_2d.sv
verif/tb_point_segment_distance_2d.sv
